// ----- src/pfpes_pkg.sv -----
// Shared types, constants and command tables of the parallel flash sequencer.
package pfpes_pkg;

	localparam int BUF_DEPTH   = 4096;
	localparam int BUF_AW      = $clog2(BUF_DEPTH);
	localparam int MAX_UNIT    = 32;
	localparam int RETRY_LIMIT = 20;
	localparam int UNIT_W      = 6;
	localparam int TOGGLE_BIT  = 6;

	localparam logic [7:0] CMD_UNLOCK1     = 8'hAA;
	localparam logic [7:0] CMD_UNLOCK2     = 8'h55;
	localparam logic [7:0] CMD_PROGRAM     = 8'hA0;
	localparam logic [7:0] CMD_ERASE_SETUP = 8'h80;
	localparam logic [7:0] CMD_CHIP_ERASE  = 8'h10;
	localparam logic [7:0] ERASED_BYTE     = 8'hFF;

	typedef enum logic [1:0] {
		OP_LOAD    = 2'd0,
		OP_PROGRAM = 2'd1,
		OP_ERASE   = 2'd2,
		OP_TICK    = 2'd3
	} opcode_t;

	typedef enum logic [1:0] {
		AK_NONE  = 2'd0,
		AK_WRITE = 2'd1,
		AK_POLL  = 2'd2
	} access_kind_t;

	typedef enum logic [2:0] {
		PH_IDLE         = 3'd0,
		PH_ERASE        = 3'd1,
		PH_ERASE_WAIT   = 3'd2,
		PH_PROGRAM      = 3'd3,
		PH_TOGGLE_FIRST = 3'd4,
		PH_TOGGLE_CHECK = 3'd5
	} phase_t;

	typedef enum logic [3:0] {
		CFG_UNLOCK_A     = 4'd0,
		CFG_UNLOCK_B     = 4'd1,
		CFG_UNIT_BYTES   = 4'd2,
		CFG_VERIFY_RETRY = 4'd3
	} cfg_index_t;

	// Bus command sequences driven out of the table below
	typedef enum logic [1:0] {
		SQ_NONE   = 2'd0,
		SQ_POLL   = 2'd1,
		SQ_ERASE  = 2'd2,
		SQ_UNLOCK = 2'd3
	} seq_t;

	typedef enum logic [1:0] {
		AS_ZERO     = 2'd0,
		AS_UNLOCK_A = 2'd1,
		AS_UNLOCK_B = 2'd2,
		AS_BASE     = 2'd3
	} addr_sel_t;

	typedef struct packed {
		access_kind_t kind;
		addr_sel_t    asel;
		logic [7:0]   data;
		logic         fin;
	} beat_def_t;

	typedef struct packed {
		logic [15:0]       unlock_a;
		logic [15:0]       unlock_b;
		logic [UNIT_W-1:0] unit;
		logic              retry_on;
	} cfg_t;

	typedef struct packed {
		opcode_t     opcode;
		logic [11:0] buffer_index;
		logic [7:0]  buffer_byte;
		logic [15:0] target_address;
		logic [12:0] byte_count;
		logic [7:0]  poll_byte;
		logic        verify_ok;
	} in_item_t;

	typedef struct packed {
		access_kind_t kind;
		logic [15:0]  addr;
		logic [7:0]   data;
		phase_t       phase;
		logic [4:0]   retry;
		logic         last;
	} beat_t;

	typedef struct packed {
		logic              we;
		logic              re;
		logic [BUF_AW-1:0] addr;
		logic [7:0]        wdata;
	} ram_req_t;

	function automatic beat_def_t seq_beat(seq_t seq, logic [2:0] idx);
		beat_def_t d;
		unique case (seq)
			SQ_NONE: d = '{AK_NONE, AS_ZERO, 8'h00, 1'b1};
			SQ_POLL: d = '{AK_POLL, AS_BASE, 8'h00, 1'b1};
			SQ_ERASE: begin
				unique case (idx)
					3'd0:    d = '{AK_WRITE, AS_UNLOCK_A, CMD_UNLOCK1, 1'b0};
					3'd1:    d = '{AK_WRITE, AS_UNLOCK_B, CMD_UNLOCK2, 1'b0};
					3'd2:    d = '{AK_WRITE, AS_UNLOCK_A, CMD_ERASE_SETUP, 1'b0};
					3'd3:    d = '{AK_WRITE, AS_UNLOCK_A, CMD_UNLOCK1, 1'b0};
					3'd4:    d = '{AK_WRITE, AS_UNLOCK_B, CMD_UNLOCK2, 1'b0};
					default: d = '{AK_WRITE, AS_UNLOCK_A, CMD_CHIP_ERASE, 1'b1};
				endcase
			end
			SQ_UNLOCK: begin
				unique case (idx)
					3'd0:    d = '{AK_WRITE, AS_UNLOCK_A, CMD_UNLOCK1, 1'b0};
					3'd1:    d = '{AK_WRITE, AS_UNLOCK_B, CMD_UNLOCK2, 1'b0};
					default: d = '{AK_WRITE, AS_UNLOCK_A, CMD_PROGRAM, 1'b1};
				endcase
			end
			default: d = '{AK_NONE, AS_ZERO, 8'h00, 1'b1};
		endcase
		return d;
	endfunction

endpackage

// ----- src/pfpes_ram.sv -----
// Generic single-port RAM with registered read data.
module pfpes_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		// hold read data between reads
		if (re) begin
			rdata_q <= mem_q[addr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ----- src/pfpes_seq.sv -----
// Sequencer: item decode, flash state and bus beat generation with buffer and bus address steppers.
module pfpes_seq import pfpes_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  cfg_t       cfg,
	input  logic       in_valid,
	output logic       in_ready,
	input  in_item_t   in_item,
	output ram_req_t   ram_req,
	input  logic [7:0] ram_rdata,
	output logic       out_valid,
	input  logic       out_ready,
	output beat_t      out_beat
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHK,
		ST_CMD,
		ST_RD,
		ST_DAT
	} st_t;

	st_t               st_q;
	phase_t            phase_q;
	logic              erase_q;
	logic [15:0]       cur_q;
	logic [BUF_AW-1:0] off_q;
	logic [12:0]       left_q;
	logic              toggle_q;
	logic [4:0]        retry_q;
	logic [15:0]       base_q;
	seq_t              seq_q;
	logic [2:0]        idx_q;
	logic [UNIT_W-1:0] cnt_q;
	logic [BUF_AW-1:0] rd_ptr_q;
	logic [15:0]       wr_addr_q;
	logic              out_valid_q;
	beat_t             beat_q;

	logic              accept;
	logic              out_free;
	logic              prog_tick;
	logic              dat_last;
	logic              poll_dq6;
	logic              load;
	beat_t             ld_beat;
	beat_def_t         def;
	logic [15:0]       def_addr;

	phase_t            nx_phase;
	logic              nx_erase;
	logic [15:0]       nx_cur;
	logic [BUF_AW-1:0] nx_off;
	logic [12:0]       nx_left;
	logic              nx_toggle;
	logic [4:0]        nx_retry;
	seq_t              nx_seq;

	assign in_ready  = (st_q == ST_IDLE);
	assign accept    = in_valid && in_ready;
	assign out_free  = !out_valid_q || out_ready;
	assign prog_tick = (in_item.opcode == OP_TICK) && (phase_q == PH_PROGRAM);
	assign dat_last  = (cnt_q == cfg.unit - UNIT_W'(1));
	assign poll_dq6  = in_item.poll_byte[TOGGLE_BIT];

	// State update of one accepted item
	always_comb begin
		nx_phase  = phase_q;
		nx_erase  = erase_q;
		nx_cur    = cur_q;
		nx_off    = off_q;
		nx_left   = left_q;
		nx_toggle = toggle_q;
		nx_retry  = retry_q;
		nx_seq    = SQ_NONE;
		unique case (in_item.opcode)
			OP_LOAD: begin
			end
			OP_PROGRAM, OP_ERASE: begin
				nx_erase = (in_item.opcode == OP_ERASE);
				nx_phase = nx_erase ? PH_ERASE : PH_PROGRAM;
				nx_cur   = in_item.target_address;
				nx_left  = nx_erase ? 13'(cfg.unit) : in_item.byte_count;
				nx_off   = '0;
				nx_retry = '0;
			end
			OP_TICK: begin
				unique case (phase_q)
					PH_ERASE: begin
						nx_seq   = SQ_ERASE;
						nx_phase = PH_ERASE_WAIT;
					end
					PH_ERASE_WAIT: begin
						nx_seq = SQ_POLL;
						if (in_item.poll_byte == ERASED_BYTE) begin
							nx_phase = PH_IDLE;
						end
					end
					PH_PROGRAM: begin
						nx_phase = PH_TOGGLE_FIRST;
					end
					PH_TOGGLE_FIRST: begin
						nx_seq    = SQ_POLL;
						nx_toggle = poll_dq6;
						nx_phase  = PH_TOGGLE_CHECK;
					end
					PH_TOGGLE_CHECK: begin
						nx_seq    = SQ_POLL;
						nx_toggle = poll_dq6;
						if (toggle_q == poll_dq6) begin
							if (cfg.retry_on && !erase_q && retry_q < 5'(RETRY_LIMIT) &&
							    !in_item.verify_ok) begin
								// reprogram the unit, keep the toggle sample
								nx_retry  = retry_q + 5'd1;
								nx_phase  = PH_PROGRAM;
								nx_toggle = toggle_q;
							end else begin
								nx_retry = '0;
								nx_cur   = cur_q + 16'(cfg.unit);
								nx_off   = off_q + BUF_AW'(cfg.unit);
								nx_left  = (left_q > 13'(cfg.unit)) ? left_q - 13'(cfg.unit) : '0;
								nx_phase = (nx_left == '0 || erase_q) ? PH_IDLE : PH_PROGRAM;
							end
						end
					end
					default: nx_phase = PH_IDLE;
				endcase
			end
			default: begin
			end
		endcase
	end

	// Beat selection
	always_comb begin
		def = seq_beat(seq_q, idx_q);
		unique case (def.asel)
			AS_ZERO:     def_addr = '0;
			AS_UNLOCK_A: def_addr = cfg.unlock_a;
			AS_UNLOCK_B: def_addr = cfg.unlock_b;
			AS_BASE:     def_addr = base_q;
			default:     def_addr = '0;
		endcase
		load    = 1'b0;
		ld_beat = '{def.kind, def_addr, def.data, phase_q, retry_q,
		            def.fin && (seq_q != SQ_UNLOCK)};
		if (st_q == ST_CMD) begin
			load = out_free;
		end else if (st_q == ST_DAT) begin
			load    = out_free;
			ld_beat = '{AK_WRITE, wr_addr_q, ram_rdata, phase_q, retry_q, dat_last};
		end
	end

	// Buffer port: load writes, skip check and byte fetch
	always_comb begin
		ram_req.we    = accept && (in_item.opcode == OP_LOAD);
		ram_req.wdata = in_item.buffer_byte;
		ram_req.re    = 1'b0;
		ram_req.addr  = in_item.buffer_index[BUF_AW-1:0];
		unique case (st_q)
			ST_IDLE: begin
				if (accept && prog_tick) begin
					ram_req.re   = 1'b1;
					ram_req.addr = off_q;
				end
			end
			ST_RD: begin
				ram_req.re   = 1'b1;
				ram_req.addr = rd_ptr_q;
			end
			ST_DAT: begin
				// fetch ahead while the current byte leaves
				if (out_free && !dat_last) begin
					ram_req.re   = 1'b1;
					ram_req.addr = rd_ptr_q + BUF_AW'(1);
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ST_IDLE;
			phase_q     <= PH_IDLE;
			erase_q     <= 1'b0;
			cur_q       <= '0;
			off_q       <= '0;
			left_q      <= '0;
			toggle_q    <= 1'b0;
			retry_q     <= '0;
			base_q      <= '0;
			seq_q       <= SQ_NONE;
			idx_q       <= '0;
			cnt_q       <= '0;
			rd_ptr_q    <= '0;
			wr_addr_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (st_q)
				ST_IDLE: begin
					if (accept) begin
						phase_q  <= nx_phase;
						erase_q  <= nx_erase;
						cur_q    <= nx_cur;
						off_q    <= nx_off;
						left_q   <= nx_left;
						toggle_q <= nx_toggle;
						retry_q  <= nx_retry;
						base_q   <= cur_q;
						seq_q    <= nx_seq;
						idx_q    <= '0;
						st_q     <= prog_tick ? ST_CHK : ST_CMD;
					end
				end
				ST_CHK: begin
					// a one-byte unit of erased value needs no program cycle
					seq_q <= (cfg.unit == UNIT_W'(1) && ram_rdata == ERASED_BYTE) ?
					         SQ_NONE : SQ_UNLOCK;
					idx_q <= '0;
					st_q  <= ST_CMD;
				end
				ST_CMD: begin
					if (out_free) begin
						if (def.fin) begin
							if (seq_q == SQ_UNLOCK) begin
								cnt_q     <= '0;
								rd_ptr_q  <= off_q;
								wr_addr_q <= base_q;
								st_q      <= ST_RD;
							end else begin
								st_q <= ST_IDLE;
							end
						end else begin
							idx_q <= idx_q + 3'd1;
						end
					end
				end
				ST_RD: begin
					st_q <= ST_DAT;
				end
				ST_DAT: begin
					if (out_free) begin
						if (dat_last) begin
							st_q <= ST_IDLE;
						end else begin
							cnt_q     <= cnt_q + UNIT_W'(1);
							rd_ptr_q  <= rd_ptr_q + BUF_AW'(1);
							wr_addr_q <= wr_addr_q + 16'd1;
						end
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			beat_q <= ld_beat;
		end
	end

	assign out_valid = out_valid_q;
	assign out_beat  = beat_q;

endmodule

// ----- src/parallel_flash_program_erase_sequencer.sv -----
// Flow: an accepted item enters the command state, which loads the output register when it is free;
// a program tick passes a skip check first. Throughput: one beat per cycle while m_tready is high,
// bar gaps between items and before program data; a skipped tick sends one no-access beat.
// Input is not taken again until the last beat of an item sits in the output register.
// Reset: arst_n clears sequencer state and loads config defaults; no buffer clearing pass,
// the page buffer holds undefined data until loaded.
module parallel_flash_program_erase_sequencer import pfpes_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// buffer_index, buffer_byte, target_address, byte_count, poll_byte, verify_ok, zero pad
	input  logic [63:0] s_tdata,
	// opcode
	input  logic [1:0]  s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// bus_address, bus_data, phase_now, retry_tally
	output logic [31:0] m_tdata,
	// access_kind
	output logic [1:0]  m_tuser,
	output logic        m_tlast,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [3:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	logic [15:0]       unlock_a_q;
	logic [15:0]       unlock_b_q;
	logic [UNIT_W-1:0] unit_q;
	logic              retry_on_q;
	cfg_t              cfg;
	in_item_t          item;
	ram_req_t          ram_req;
	logic [7:0]        ram_rdata;
	beat_t             beat;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			unlock_a_q <= 16'h5555;
			unlock_b_q <= 16'h2AAA;
			unit_q     <= UNIT_W'(1);
			retry_on_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index_t'(cfg_index))
				CFG_UNLOCK_A:     unlock_a_q <= cfg_data;
				CFG_UNLOCK_B:     unlock_b_q <= cfg_data;
				CFG_UNIT_BYTES:   unit_q     <= cfg_data[UNIT_W-1:0];
				CFG_VERIFY_RETRY: retry_on_q <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	// clamp the unit to one..MAX_UNIT
	always_comb begin
		cfg.unlock_a = unlock_a_q;
		cfg.unlock_b = unlock_b_q;
		cfg.retry_on = retry_on_q;
		if (unit_q == '0) begin
			cfg.unit = UNIT_W'(1);
		end else if (unit_q > UNIT_W'(MAX_UNIT)) begin
			cfg.unit = UNIT_W'(MAX_UNIT);
		end else begin
			cfg.unit = unit_q;
		end
	end

	assign item.opcode         = opcode_t'(s_tuser);
	assign item.buffer_index   = s_tdata[11:0];
	assign item.buffer_byte    = s_tdata[19:12];
	assign item.target_address = s_tdata[35:20];
	assign item.byte_count     = s_tdata[48:36];
	assign item.poll_byte      = s_tdata[56:49];
	assign item.verify_ok      = s_tdata[57];

	pfpes_ram #(
		.WIDTH(8),
		.DEPTH(BUF_DEPTH)
	) u_buf (
		.clk  (clk),
		.we   (ram_req.we),
		.re   (ram_req.re),
		.addr (ram_req.addr),
		.wdata(ram_req.wdata),
		.rdata(ram_rdata)
	);

	pfpes_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.in_item  (item),
		.ram_req  (ram_req),
		.ram_rdata(ram_rdata),
		.out_valid(m_tvalid),
		.out_ready(m_tready),
		.out_beat (beat)
	);

	assign m_tdata = {beat.retry, beat.phase, beat.data, beat.addr};
	assign m_tuser = beat.kind;
	assign m_tlast = beat.last;

`ifndef SYNTH
	a_none_is_single: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == AK_NONE |-> m_tlast && m_tdata[23:0] == 24'd0)
		else $error("no-access beat not a lone zero beat");

	a_poll_is_single: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == AK_POLL |-> m_tlast && m_tdata[23:16] == 8'd0)
		else $error("poll read beat carries data or is not last");

	a_retry_bound: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[31:27] <= 5'(RETRY_LIMIT))
		else $error("retry tally beyond limit");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input taken again before item finished");
`endif

endmodule
